>>> src/rmh_pkg.sv
// Shared types and constants for the running median block.
package rmh_pkg;

  localparam int DEF_CAPACITY    = 1024;
  localparam int DEF_SAMPLE_BITS = 16;

  // command from the sequencer to one heap
  typedef struct packed {
    logic go;
    logic pop;
  } rmh_cmd_t;

  // status back from one heap
  typedef struct packed {
    logic done;
  } rmh_stat_t;

endpackage

>>> src/rmh_heap.sv
// Binary heap over a single-port RAM with a sift-up / sift-down sequencer.
module rmh_heap import rmh_pkg::*; #(
  parameter int DEPTH       = (DEF_CAPACITY + 1) / 2,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter bit MAX_HEAP    = 1'b1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rmh_cmd_t                      cmd,
  input  logic signed [SAMPLE_BITS-1:0] push_val,
  output rmh_stat_t                     stat,
  output logic signed [SAMPLE_BITS-1:0] top,
  output logic [$clog2(DEPTH+1)-1:0]    size
);

  localparam int AW = $clog2(DEPTH);
  localparam int SW = $clog2(DEPTH + 1);
  localparam int IW = AW + 2;

  localparam logic [2:0] H_IDLE  = 3'd0;
  localparam logic [2:0] H_PUSH  = 3'd1;
  localparam logic [2:0] H_PUCMP = 3'd2;
  localparam logic [2:0] H_POP1  = 3'd3;
  localparam logic [2:0] H_POPL  = 3'd4;
  localparam logic [2:0] H_POPR  = 3'd5;
  localparam logic [2:0] H_POPC  = 3'd6;

  logic signed [SAMPLE_BITS-1:0] mem [DEPTH];

  logic [2:0]                    state_r, state_nxt;
  logic [AW-1:0]                 i_r, i_nxt;
  logic [SW-1:0]                 n_r, n_nxt;
  logic [SW-1:0]                 size_r, size_nxt;
  logic signed [SAMPLE_BITS-1:0] v_r, v_nxt;
  logic signed [SAMPLE_BITS-1:0] lv_r, lv_nxt;
  logic signed [SAMPLE_BITS-1:0] rdata_r;
  logic signed [SAMPLE_BITS-1:0] top_r;

  logic                          we;
  logic [AW-1:0]                 wa;
  logic signed [SAMPLE_BITS-1:0] wd;
  logic [AW-1:0]                 rd_addr;
  logic                          done;

  logic [IW-1:0]                 l_w, r_w, n_ext;
  logic [AW-1:0]                 p_w;
  logic                          take_l, take_r;
  logic signed [SAMPLE_BITS-1:0] best_v;

  function automatic logic above(logic signed [SAMPLE_BITS-1:0] a,
                                 logic signed [SAMPLE_BITS-1:0] b);
    return MAX_HEAP ? (a > b) : (a < b);
  endfunction

  assign l_w   = ({{(IW-AW){1'b0}}, i_r} << 1) + IW'(1);
  assign r_w   = l_w + IW'(1);
  assign n_ext = IW'(n_r);
  assign p_w   = (i_r - AW'(1)) >> 1;

  assign take_l = above(lv_r, v_r);
  assign best_v = take_l ? lv_r : v_r;
  assign take_r = (r_w < n_ext) && above(rdata_r, best_v);

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    n_nxt     = n_r;
    size_nxt  = size_r;
    v_nxt     = v_r;
    lv_nxt    = lv_r;
    we        = 1'b0;
    wa        = i_r;
    wd        = v_r;
    rd_addr   = '0;
    done      = 1'b0;
    case (state_r)
      H_IDLE: begin
        if (cmd.go && !cmd.pop) begin
          if (size_r == SW'(DEPTH)) begin
            done = 1'b1;
          end else begin
            i_nxt     = size_r[AW-1:0];
            size_nxt  = size_r + SW'(1);
            v_nxt     = push_val;
            state_nxt = H_PUSH;
          end
        end else if (cmd.go) begin
          if (size_r == '0) begin
            done = 1'b1;
          end else begin
            rd_addr   = AW'(size_r - SW'(1));
            size_nxt  = size_r - SW'(1);
            n_nxt     = size_r - SW'(1);
            i_nxt     = '0;
            state_nxt = H_POP1;
          end
        end
      end
      H_PUSH: begin
        if (i_r == '0) begin
          we        = 1'b1;
          done      = 1'b1;
          state_nxt = H_IDLE;
        end else begin
          rd_addr   = p_w;
          state_nxt = H_PUCMP;
        end
      end
      H_PUCMP: begin
        we = 1'b1;
        if (above(v_r, rdata_r)) begin
          // parent moves down, hole moves up
          wd        = rdata_r;
          i_nxt     = p_w;
          state_nxt = H_PUSH;
        end else begin
          done      = 1'b1;
          state_nxt = H_IDLE;
        end
      end
      H_POP1: begin
        v_nxt     = rdata_r;
        state_nxt = H_POPL;
      end
      H_POPL: begin
        if (l_w >= n_ext) begin
          we        = 1'b1;
          done      = 1'b1;
          state_nxt = H_IDLE;
        end else begin
          rd_addr   = l_w[AW-1:0];
          state_nxt = H_POPR;
        end
      end
      H_POPR: begin
        lv_nxt    = rdata_r;
        rd_addr   = r_w[AW-1:0];
        state_nxt = H_POPC;
      end
      H_POPC: begin
        we = 1'b1;
        if (take_r) begin
          wd        = rdata_r;
          i_nxt     = r_w[AW-1:0];
          state_nxt = H_POPL;
        end else if (take_l) begin
          wd        = lv_r;
          i_nxt     = l_w[AW-1:0];
          state_nxt = H_POPL;
        end else begin
          done      = 1'b1;
          state_nxt = H_IDLE;
        end
      end
      default: state_nxt = H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
      size_r  <= '0;
    end else begin
      state_r <= state_nxt;
      size_r  <= size_nxt;
    end
    i_r  <= i_nxt;
    n_r  <= n_nxt;
    v_r  <= v_nxt;
    lv_r <= lv_nxt;
    if (we && wa == '0) top_r <= wd;
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rdata_r <= mem[rd_addr];
  end

  assign stat.done = done;
  assign top       = top_r;
  assign size      = size_r;

endmodule

>>> src/running_median_two_heaps.sv
// Running median tracker: a max-heap of the lower half, a min-heap of the upper half.
//
// Input channel in_valid/in_ready carries one signed sample per request.
// Output channel out_valid/out_ready returns one result per request:
// out_median_x2 (twice the median, one fractional bit), out_count (samples
// held) and out_rejected (store full, sample dropped, set unchanged).
// The block works on one request at a time; in_ready is high only while
// the sequencer is idle. A request runs up to three heap operations in
// turn: a push climbs the heap a level at a time and a pop descends it a
// level at a time, each limited by the single RAM port of its heap.
// When the result is registered the sequencer is idle again, so the next
// request can be accepted while that result is presented.
// The result sits in an output register; a new request is accepted while
// it waits, and a finished request holds in its last state while the
// receiver stalls and the register is still full.
// Reset clears the heap sizes and all handshake state; heap RAM contents
// are not cleared and need no clearing pass.
module running_median_two_heaps import rmh_pkg::*; #(
  parameter int CAPACITY    = DEF_CAPACITY,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS:0]   out_median_x2,
  output logic [$clog2(CAPACITY+1)-1:0] out_count,
  output logic                          out_rejected
);

  localparam int DEPTH = (CAPACITY + 1) / 2;
  localparam int SW    = $clog2(DEPTH + 1);
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int MW    = SAMPLE_BITS + 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  localparam logic LOWER = 1'b0;
  localparam logic UPPER = 1'b1;

  logic [1:0]                    state_r, state_nxt;
  logic [1:0]                    step_r, step_nxt;
  logic [1:0]                    nops_r, nops_nxt;
  logic [2:0]                    sel_r, sel_nxt;
  logic [2:0]                    pop_r, pop_nxt;
  logic signed [SAMPLE_BITS-1:0] val_r [3];
  logic signed [SAMPLE_BITS-1:0] val_nxt [3];
  logic                          rej_r, rej_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic signed [MW-1:0]          med_r, med_nxt;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic                          orej_r, orej_nxt;

  rmh_cmd_t                      lo_cmd, up_cmd;
  rmh_stat_t                     lo_stat, up_stat;
  logic signed [SAMPLE_BITS-1:0] lo_top, up_top;
  logic [SW-1:0]                 lo_size, up_size;
  logic signed [SAMPLE_BITS-1:0] push_v;

  logic [CW-1:0]                 count_w;
  logic signed [MW-1:0]          med2_w, x2_w;
  logic                          cur_sel, cur_done;

  assign count_w = CW'(lo_size) + CW'(up_size);
  assign x2_w    = {in_sample, 1'b0};

  always_comb begin
    if (lo_size == '0 && up_size == '0) med2_w = '0;
    else if (lo_size == up_size)        med2_w = MW'(lo_top) + MW'(up_top);
    else if (lo_size < up_size)         med2_w = {up_top, 1'b0};
    else                                med2_w = {lo_top, 1'b0};
  end

  assign cur_sel  = sel_r[step_r];
  assign cur_done = cur_sel ? up_stat.done : lo_stat.done;
  assign push_v   = val_r[step_r];

  always_comb begin
    lo_cmd.go  = 1'b0;
    up_cmd.go  = 1'b0;
    lo_cmd.pop = pop_r[step_r];
    up_cmd.pop = pop_r[step_r];
    if (state_r == S_ISSUE) begin
      if (cur_sel == UPPER) up_cmd.go = 1'b1;
      else                  lo_cmd.go = 1'b1;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    nops_nxt      = nops_r;
    sel_nxt       = sel_r;
    pop_nxt       = pop_r;
    val_nxt       = val_r;
    rej_nxt       = rej_r;
    out_valid_nxt = out_valid_r && !out_ready;
    med_nxt       = med_r;
    cnt_nxt       = cnt_r;
    orej_nxt      = orej_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          step_nxt   = '0;
          rej_nxt    = 1'b0;
          pop_nxt    = 3'b000;
          val_nxt[0] = in_sample;
          val_nxt[1] = in_sample;
          val_nxt[2] = in_sample;
          nops_nxt   = 2'd1;
          state_nxt  = S_ISSUE;
          if (count_w >= CW'(CAPACITY)) begin
            rej_nxt   = 1'b1;
            nops_nxt  = 2'd0;
            state_nxt = S_FIN;
          end else if (lo_size == '0) begin
            sel_nxt[0] = LOWER;
          end else if (lo_size == up_size) begin
            sel_nxt[0] = (x2_w <= med2_w) ? LOWER : UPPER;
          end else if (lo_size < up_size) begin
            if (x2_w > med2_w) begin
              // upper top crosses to the lower side
              sel_nxt    = {UPPER, UPPER, LOWER};
              pop_nxt    = 3'b010;
              val_nxt[0] = up_top;
              nops_nxt   = 2'd3;
            end else begin
              sel_nxt[0] = LOWER;
            end
          end else begin
            if (x2_w < med2_w) begin
              sel_nxt    = {LOWER, LOWER, UPPER};
              pop_nxt    = 3'b010;
              val_nxt[0] = lo_top;
              nops_nxt   = 2'd3;
            end else begin
              sel_nxt[0] = UPPER;
            end
          end
        end
      end
      S_ISSUE: begin
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (cur_done) begin
          if (step_r + 2'd1 == nops_r) begin
            state_nxt = S_FIN;
          end else begin
            step_nxt  = step_r + 2'd1;
            state_nxt = S_ISSUE;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          med_nxt       = med2_w;
          cnt_nxt       = count_w;
          orej_nxt      = rej_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    step_r <= step_nxt;
    nops_r <= nops_nxt;
    sel_r  <= sel_nxt;
    pop_r  <= pop_nxt;
    val_r  <= val_nxt;
    rej_r  <= rej_nxt;
    med_r  <= med_nxt;
    cnt_r  <= cnt_nxt;
    orej_r <= orej_nxt;
  end

  rmh_heap #(.DEPTH(DEPTH), .SAMPLE_BITS(SAMPLE_BITS), .MAX_HEAP(1'b1)) u_lower (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (lo_cmd),
    .push_val (push_v),
    .stat     (lo_stat),
    .top      (lo_top),
    .size     (lo_size)
  );

  rmh_heap #(.DEPTH(DEPTH), .SAMPLE_BITS(SAMPLE_BITS), .MAX_HEAP(1'b0)) u_upper (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (up_cmd),
    .push_val (push_v),
    .stat     (up_stat),
    .top      (up_top),
    .size     (up_size)
  );

  assign out_valid     = out_valid_r;
  assign out_median_x2 = med_r;
  assign out_count     = cnt_r;
  assign out_rejected  = orej_r;

`ifndef ASSERT_OFF
  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_w <= CW'(CAPACITY))
    else $error("sample count above capacity");

  a_balance: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> (lo_size == up_size) || (lo_size == up_size + SW'(1))
                          || (up_size == lo_size + SW'(1)))
    else $error("heap sizes out of balance");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(lo_stat.done && up_stat.done))
    else $error("both heaps busy at once");
`endif

endmodule
